// File: hdl/assert_macros.svh
// Assertion macros shared by the date stepping block.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication under reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/dmd_pkg.sv
// Shared types, constants and calendar functions for date_minus_days.
// Depends on nothing.
package dmd_pkg;

	localparam int DAY_W = 5;
	localparam int MON_W = 4;
	localparam int YEAR_W = 14;
	localparam int DOY_W = 9;
	localparam int R400_W = 9;
	localparam int DAYS_BACK_BITS_DEF = 16;
	localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
	localparam logic [YEAR_W-1:0] CYCLE_YEARS = YEAR_W'(400);
	localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
	localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

	typedef logic alu_op_t;
	localparam alu_op_t ALU_SUB = 1'b0;
	localparam alu_op_t ALU_ADD = 1'b1;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Leap test from the year modulo 400.
	function automatic logic is_leap(input logic [R400_W-1:0] r);
		return (r[1:0] == 2'b00) && (r != R400_W'(100)) && (r != R400_W'(200))
			&& (r != R400_W'(300));
	endfunction

	function automatic logic [R400_W-1:0] r400_prev(input logic [R400_W-1:0] r);
		return (r == '0) ? R400_W'(399) : r - R400_W'(1);
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic leap,
			input logic [MON_W-1:0] m);
		logic [3:0] idx;
		idx = (m == '0) ? 4'd0 : ((m > MON_DEC) ? 4'd11 : m - 4'd1);
		if (m == MON_FEB && leap)
			return DAY_W'(29);
		return MONTH_LEN[idx];
	endfunction

	// Last zero-based day of the year.
	function automatic logic [DOY_W-1:0] year_last_doy(input logic leap);
		return leap ? DOY_W'(365) : DOY_W'(364);
	endfunction

endpackage

// File: hdl/dmd_alu.sv
// Shared add/subtract and compare unit for the date sequencer.
// Depends on dmd_pkg.
module dmd_alu import dmd_pkg::*; #(
	parameter int W = 16
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] res,
	output logic         ge
);

	logic [W:0] diff;

	assign diff = {1'b0, a} - {1'b0, b};
	assign ge = ~diff[W];

	always_comb begin
		case (op)
			ALU_ADD: res = a + b;
			ALU_SUB: res = diff[W-1:0];
			default: res = diff[W-1:0];
		endcase
	end

endmodule

// File: hdl/date_minus_days.sv
// Top level of date_minus_days: sequencer, working registers and shared ALU.
// Depends on dmd_pkg, dmd_alu and assert_macros.svh.
//
// Usage: drive day_in, month_in, year_in and days_back and raise start while
// busy is low; the word is taken at that edge. busy stays high until the
// result has been shown. The result appears on day_out, month_out, year_out
// and hit_floor for exactly one cycle, marked by done; the receiver cannot
// stall it. Out-of-range inputs are clamped to the nearest valid date.
// Steps: reduce the year modulo 400, sum the month lengths before the start
// month and the start day into a zero-based day of year, step back one year
// at a time while the remaining days cover the day of year plus one, finish
// the day of year (skipped at the floor), walk forward through the months and
// show the result; the next word is taken once busy has dropped. Every
// arithmetic step uses the single shared add/subtract unit.
// Reset returns the sequencer to idle and drops busy and done.
`include "assert_macros.svh"
module date_minus_days import dmd_pkg::*; #(
	parameter int DAYS_BACK_BITS = DAYS_BACK_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [DAY_W-1:0]          day_in,
	input  logic [MON_W-1:0]          month_in,
	input  logic [YEAR_W-1:0]         year_in,
	input  logic [DAYS_BACK_BITS-1:0] days_back,
	output logic                      done,
	output logic [DAY_W-1:0]          day_out,
	output logic [MON_W-1:0]          month_out,
	output logic [YEAR_W-1:0]         year_out,
	output logic                      hit_floor
);

	localparam int AW = (DAYS_BACK_BITS > YEAR_W) ? DAYS_BACK_BITS : YEAR_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MOD   = 3'd1;
	localparam logic [2:0] S_DOY   = 3'd2;
	localparam logic [2:0] S_YEAR  = 3'd3;
	localparam logic [2:0] S_FIX   = 3'd4;
	localparam logic [2:0] S_MONTH = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]                state_q;
	logic [AW-1:0]             rem_q;
	logic [YEAR_W-1:0]         y_q;
	logic [YEAR_W-1:0]         r400_q;
	logic [DOY_W-1:0]          doy_q;
	logic [MON_W-1:0]          m_q;
	logic [MON_W-1:0]          mt_q;
	logic [DAY_W-1:0]          d_q;
	logic                      floor_q;

	alu_op_t                   alu_op;
	logic [AW-1:0]             alu_a;
	logic [AW-1:0]             alu_b;
	logic [AW-1:0]             alu_res;
	logic                      alu_ge;

	logic                      leap_cur;
	logic [R400_W-1:0]         r_prev;
	logic [DAY_W-1:0]          dim_m;
	logic [DAY_W-1:0]          dim_t;
	logic [DAY_W-1:0]          d_clamp;
	logic [MON_W-1:0]          m_in_c;
	logic [YEAR_W-1:0]         y_in_c;

	assign leap_cur = is_leap(r400_q[R400_W-1:0]);
	assign r_prev = r400_prev(r400_q[R400_W-1:0]);
	assign dim_m = month_days(leap_cur, m_q);
	assign dim_t = month_days(leap_cur, mt_q);
	assign d_clamp = (d_q > dim_t) ? dim_t : d_q;

	assign m_in_c = (month_in == '0) ? MON_W'(1) : ((month_in > MON_DEC) ? MON_DEC : month_in);
	assign y_in_c = (year_in == '0) ? YEAR_W'(1) : ((year_in > YEAR_MAX) ? YEAR_MAX : year_in);

	always_comb begin
		alu_op = ALU_SUB;
		alu_a = AW'(doy_q);
		alu_b = AW'(dim_m);
		case (state_q)
			S_MOD: begin
				alu_a = AW'(r400_q);
				alu_b = AW'(CYCLE_YEARS);
			end
			S_DOY: begin
				alu_op = ALU_ADD;
				alu_b = (m_q == mt_q) ? AW'(d_clamp - DAY_W'(1)) : AW'(dim_m);
			end
			S_YEAR: begin
				alu_a = rem_q;
				alu_b = AW'(doy_q) + AW'(1);
			end
			S_FIX: begin
				alu_b = rem_q;
			end
			default: begin
				alu_b = AW'(dim_m);
			end
		endcase
	end

	dmd_alu #(.W(AW)) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.ge  (alu_ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (start) state_q <= S_MOD;
				S_MOD:   if (!alu_ge) state_q <= S_DOY;
				S_DOY:   if (m_q == mt_q) state_q <= S_YEAR;
				S_YEAR: begin
					if (!alu_ge)
						state_q <= S_FIX;
					else if (y_q == YEAR_W'(1))
						state_q <= S_MONTH;
				end
				S_FIX:   state_q <= S_MONTH;
				S_MONTH: if (!(m_q < MON_DEC && alu_ge)) state_q <= S_DONE;
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					rem_q <= AW'(days_back);
					y_q <= y_in_c;
					r400_q <= y_in_c;
					mt_q <= m_in_c;
					d_q <= (day_in == '0) ? DAY_W'(1) : day_in;
					floor_q <= 1'b0;
				end
			end
			S_MOD: begin
				if (alu_ge) begin
					r400_q <= alu_res[YEAR_W-1:0];
				end else begin
					m_q <= MON_W'(1);
					doy_q <= '0;
				end
			end
			S_DOY: begin
				doy_q <= alu_res[DOY_W-1:0];
				if (m_q != mt_q)
					m_q <= m_q + MON_W'(1);
			end
			S_YEAR: begin
				if (alu_ge) begin
					if (y_q == YEAR_W'(1)) begin
						doy_q <= '0;
						floor_q <= 1'b1;
						m_q <= MON_W'(1);
					end else begin
						rem_q <= alu_res;
						y_q <= y_q - YEAR_W'(1);
						r400_q <= YEAR_W'(r_prev);
						doy_q <= year_last_doy(is_leap(r_prev));
					end
				end
			end
			S_FIX: begin
				doy_q <= alu_res[DOY_W-1:0];
				m_q <= MON_W'(1);
			end
			S_MONTH: begin
				if (m_q < MON_DEC && alu_ge) begin
					doy_q <= alu_res[DOY_W-1:0];
					m_q <= m_q + MON_W'(1);
				end
			end
			default: begin
				doy_q <= doy_q;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign day_out = doy_q[DAY_W-1:0] + DAY_W'(1);
	assign month_out = m_q;
	assign year_out = y_q;
	assign hit_floor = floor_q;

	`ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy && !done)
	`ASSERT_NXT(a_done_once, clk, arst_n, done, !done && !busy)
	`ASSERT_IMP(a_month_ok, clk, arst_n, done, month_out != '0 && month_out <= MON_DEC)
	`ASSERT_IMP(a_floor_date, clk, arst_n, done && hit_floor,
		year_out == YEAR_W'(1) && month_out == MON_W'(1) && day_out == DAY_W'(1))

endmodule
